@@ sv/ordered_list_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine package
// Widths, operation and status codes, and the records passed along the chain.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int OLE_CAPACITY = 64;
	localparam int DATA_W       = 16;
	localparam int OP_W         = 2;
	localparam int POS_W        = 7;
	localparam int ST_W         = 2;
	localparam int CNT_OUT_W    = 7;

	typedef enum logic [OP_W-1:0] {
		OP_SEARCH = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_POS   = 2'd3
	} status_t;

	// Operation broadcast to every cell for the whole pass.
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] value;
	} bcast_t;

	// Token walking the chain, one cell per cycle.
	typedef struct packed {
		logic              vld;
		logic              hit;
		logic [DATA_W-1:0] carry;
	} token_t;

	// Backward handoff used by delete to close the gap.
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] data;
	} pull_t;

endpackage

@@ sv/ole_cell.sv @@
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry and acts on the token in the cycle the token visits it.
// ----------------------------------------------------------------------------
module ole_cell #(
	parameter int CNT_W = 7,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ole_pkg::bcast_t     bc,
	input  logic [CNT_W-1:0]    count,
	input  logic [CNT_W-1:0]    pos,
	input  ole_pkg::token_t     tok_i,
	output ole_pkg::token_t     tok_o,
	input  ole_pkg::pull_t      pull_i,
	output ole_pkg::pull_t      pull_o
);
	import ole_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [DATA_W-1:0] entry_q;
	logic [DATA_W-1:0] entry_d;
	token_t            tok_q;
	token_t            tok_d;
	logic              in_range;
	logic              match;

	assign in_range = MY_IDX < count;
	assign match    = in_range && (entry_q == bc.value);

	always_comb begin
		entry_d    = entry_q;
		tok_d      = tok_i;
		pull_o.vld = 1'b0;
		pull_o.data = entry_q;
		if (pull_i.vld) begin
			entry_d = pull_i.data;
		end
		if (tok_i.vld) begin
			case (bc.op)
				OP_SEARCH: begin
					tok_d.hit = tok_i.hit | match;
				end
				OP_INSERT: begin
					if (MY_IDX == pos) begin
						entry_d     = bc.value;
						tok_d.carry = entry_q;
					end else if (MY_IDX > pos && MY_IDX <= count) begin
						entry_d     = tok_i.carry;
						tok_d.carry = entry_q;
					end
				end
				OP_DELETE: begin
					tok_d.hit  = tok_i.hit | match;
					// Once the first match is behind us, each entry moves up one place.
					pull_o.vld = tok_i.hit && in_range;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign tok_o = tok_q;

endmodule

@@ sv/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine
// Ordered list of 16-bit values with search, positional insert and delete.
// ----------------------------------------------------------------------------
// A result passes start_q, the token's walk over the full row of cells, one
// cell per cycle, fin_q and the output register. No new item is taken until
// the result of the last one has moved into the output register.
// Reset: arst_n clears the count and all control state; the entries are not
// cleared, since only entries below the count are ever read.
module ordered_list_engine #(
	parameter int CAPACITY = ole_pkg::OLE_CAPACITY
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ole_pkg::OP_W-1:0]     op,
	input  logic [ole_pkg::DATA_W-1:0]   item_value,
	input  logic [ole_pkg::POS_W-1:0]    position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ole_pkg::ST_W-1:0]     status,
	output logic [ole_pkg::CNT_OUT_W-1:0] entry_count
);
	import ole_pkg::*;

	// The internal count must hold CAPACITY itself and also compare against
	// a 7-bit position, so it is at least seven bits wide.
	localparam int CW_RAW = $clog2(CAPACITY + 1);
	localparam int CW     = (CW_RAW > POS_W) ? CW_RAW : POS_W;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	// Control state. busy_q covers the whole life of an item, from its
	// acceptance until its result moves into the output register.
	logic              busy_q;
	logic              start_q;
	logic              fin_q;
	logic              out_vld_q;
	logic [CW-1:0]     count_q;

	// Item held for the pass. op_q carries the effective operation: a refused
	// insert becomes a no-operation so that the cells leave the list alone.
	op_t               op_q;
	logic [DATA_W-1:0] value_q;
	logic [CW-1:0]     pos_q;
	status_t           sts_q;

	// Finished result waiting for the output register, and that register.
	status_t           fin_status_q;
	logic [CW-1:0]     fin_count_q;
	status_t           status_q;
	logic [CNT_OUT_W-1:0] entry_count_q;

	logic              in_acc;
	logic              out_free;
	logic              out_load;
	op_t               op_in;
	logic [CW-1:0]     pos_in;
	op_t               eff_op;
	status_t           pre_status;
	status_t           done_status;
	logic [CW-1:0]     done_count;

	bcast_t            bc;
	token_t            tok   [CAPACITY+1];
	pull_t             pull  [CAPACITY+1];
	token_t            last_tok;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign out_free = !out_vld_q || !out_stall;
	assign out_load = fin_q && out_free;

	assign op_in  = op_t'(op);
	assign pos_in = CW'(position);

	// Insert checks are settled at acceptance: a full list is reported before
	// a position beyond the count.
	always_comb begin
		eff_op     = op_in;
		pre_status = ST_OK;
		if (op_in == OP_INSERT) begin
			if (count_q >= CAP_CNT) begin
				eff_op     = OP_NOP;
				pre_status = ST_FULL;
			end else if (pos_in > count_q) begin
				eff_op     = OP_NOP;
				pre_status = ST_BAD_POS;
			end
		end
	end

	// The token enters cell 0 in the cycle after acceptance. The broadcast
	// operation and the old count stay fixed for the whole pass.
	assign bc.op     = op_q;
	assign bc.value  = value_q;
	assign tok[0].vld   = start_q;
	assign tok[0].hit   = 1'b0;
	assign tok[0].carry = value_q;
	assign pull[CAPACITY] = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		ole_cell #(
			.CNT_W (CW),
			.IDX   (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bc     (bc),
			.count  (count_q),
			.pos    (pos_q),
			.tok_i  (tok[g]),
			.tok_o  (tok[g+1]),
			.pull_i (pull[g+1]),
			.pull_o (pull[g])
		);
	end

	assign last_tok = tok[CAPACITY];

	// Result of the pass, formed when the token leaves the last cell.
	always_comb begin
		done_status = sts_q;
		done_count  = count_q;
		case (op_q)
			OP_SEARCH: begin
				done_status = last_tok.hit ? ST_OK : ST_NOT_FOUND;
			end
			OP_INSERT: begin
				done_status = ST_OK;
				done_count  = count_q + CW'(1);
			end
			OP_DELETE: begin
				if (last_tok.hit) begin
					done_status = ST_OK;
					done_count  = count_q - CW'(1);
				end else begin
					done_status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			start_q   <= 1'b0;
			fin_q     <= 1'b0;
			out_vld_q <= 1'b0;
			count_q   <= '0;
		end else begin
			start_q <= in_acc;
			if (in_acc) begin
				busy_q <= 1'b1;
			end
			if (last_tok.vld) begin
				fin_q   <= 1'b1;
				count_q <= done_count;
			end
			if (out_load) begin
				fin_q     <= 1'b0;
				busy_q    <= 1'b0;
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= eff_op;
			value_q <= item_value;
			pos_q   <= pos_in;
			sts_q   <= pre_status;
		end
		if (last_tok.vld) begin
			fin_status_q <= done_status;
			fin_count_q  <= done_count;
		end
		if (out_load) begin
			status_q      <= fin_status_q;
			entry_count_q <= fin_count_q[CNT_OUT_W-1:0];
		end
	end

	assign out_valid   = out_vld_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

@@ sv/ole_checker.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine checker
// Port-level checks of the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_assert.svh"

module ole_checker #(
	parameter int CAPACITY = ole_pkg::OLE_CAPACITY
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [ole_pkg::OP_W-1:0]      op,
	input logic [ole_pkg::DATA_W-1:0]    item_value,
	input logic [ole_pkg::POS_W-1:0]     position,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ole_pkg::ST_W-1:0]      status,
	input logic [ole_pkg::CNT_OUT_W-1:0] entry_count
);
	import ole_pkg::*;

	localparam logic [CNT_OUT_W-1:0] CAP_MASK = CNT_OUT_W'(CAPACITY);
	localparam logic                 CAP_WIDE = (CAPACITY > 127);

	// A held result must not change while the receiver stalls it.
	`OLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(status) && $stable(entry_count),
		"result changed while stalled")

	// The engine works on one item at a time.
	`OLE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall,
		"second item taken while one is in flight")

	// The count never exceeds the capacity.
	`OLE_ASSERT_NOW(a_count_bound, out_valid, CAP_WIDE || (entry_count <= CAP_MASK),
		"entry count above capacity")

	// A full refusal is only reported with a full list.
	`OLE_ASSERT_NOW(a_full_count, out_valid && (status == ST_FULL),
		entry_count == CAP_MASK,
		"list full reported with spare room")

endmodule

bind ordered_list_engine ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);
